/* hdl/blop_pkg.sv */
// ============================================================================
// blop_pkg: shared types and constants for the binomial lattice pricer
// Sequencer states, CSR indexes, Q2.30 rounding and payoff helpers.
// ============================================================================
package blop_pkg;

   localparam int PRICE_W = 32;  // Q16.16 price
   localparam int FACT_W  = 32;  // Q2.30 factor operand
   localparam int PROD_W  = PRICE_W + FACT_W;
   localparam int STEP_W  = 8;   // step_count register width
   localparam int ADDR_W  = 5;   // CSR byte address width

   localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
   localparam logic [30:0]        Q_ONE     = 31'h4000_0000;
   localparam logic [PROD_W:0]    Q_HALF    = (PROD_W+1)'(64'h2000_0000);

   // CSR reset values
   localparam logic [STEP_W-1:0] RST_STEP_COUNT = 8'd100;
   localparam logic [31:0]       RST_UP_FACTOR  = 32'd1107296256;
   localparam logic [30:0]       RST_DOWN       = 31'd1040187392;
   localparam logic [30:0]       RST_DISCOUNT   = 31'd1073741824;
   localparam logic [30:0]       RST_UP_PROB    = 31'd536870912;

   typedef enum logic [2:0] {
      CSR_STEP_COUNT    = 3'd0,
      CSR_UP_FACTOR     = 3'd1,
      CSR_DOWN_FACTOR   = 3'd2,
      CSR_STEP_DISCOUNT = 3'd3,
      CSR_UP_PROBABILITY = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DN_WR,    // store down-chain price, start next down multiply
      ST_DN_MUL,   // round down-chain product
      ST_LF_RD,    // read first leaf seed
      ST_LF_LD,    // latch leaf seed
      ST_LF_CHK,   // start up multiply or finish leaf
      ST_LF_MUL,   // round up product
      ST_LF_WR,    // store leaf payoff
      ST_FD_LO,    // latch node 0 at level start
      ST_FD_MUP,   // q * v_up
      ST_FD_MDN,   // (1-q) * v_down
      ST_FD_MIX,   // round mix
      ST_FD_MDS,   // mix * discount
      ST_FD_WR,    // store folded node
      ST_FIN       // hand root to output register
   } state_type;

   // Round to nearest (ties up) from Q2.30 product, saturate to 32 bits
   function automatic logic [PRICE_W-1:0] qround(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] sum;
      logic [PROD_W-30:0] r;
      sum = {1'b0, p} + Q_HALF;
      r   = sum[PROD_W:30];
      if (r[PROD_W-30:PRICE_W] != '0) begin
         return PRICE_MAX;
      end
      return r[PRICE_W-1:0];
   endfunction

   function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] st,
                                                input logic [PRICE_W-1:0] strike,
                                                input logic              put);
      if (put) begin
         return (strike > st) ? strike - st : '0;
      end
      return (st > strike) ? st - strike : '0;
   endfunction

endpackage

/* hdl/blop_mult.sv */
// ============================================================================
// blop_mult: shared 32x32 unsigned multiplier
// One registered product per cycle; the sequencer steers the operands.
// ============================================================================
module blop_mult
   import blop_pkg::*;
(
   input  logic                clock,
   input  logic [PRICE_W-1:0]  op_a,
   input  logic [FACT_W-1:0]   op_b,
   output logic [PROD_W-1:0]   prod
);

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

/* hdl/binomial_lattice_option_pricer_unit.sv */
// ============================================================================
// binomial_lattice_option_pricer_unit: CRR binomial lattice option pricer
// Prices one European call or put per word on an N-step lattice with one
// shared multiplier, a node store and a small sequencer.
// ============================================================================
//
//  channel | ports                         | direction | word
//  --------+-------------------------------+-----------+--------------------------
//  req     | req_valid/req_ready           | in        | spot, strike, is_put
//  rsp     | rsp_valid/rsp_ready           | out       | option_price (Q16.16)
//  csr     | csr_psel/penable/pwrite/...   | in/out    | lattice setup registers
//
//  N = min(step_count, MAX_STEPS) is the lattice size in use. The single 32x32
//  multiplier serves every down or up multiply while building leaves and every
//  multiply of a folded node, so it sets the time each word takes.
//  One word at a time; req_ready is high only when the sequencer is idle.
//  The result sits in an output register, so a new word may start while it
//  waits; the sequencer holds its last step until that register is free.
//  Reset is synchronous; CSRs return to their defaults, node store is not
//  cleared (every node is written before it is read).
//
module binomial_lattice_option_pricer_unit
   import blop_pkg::*;
#(
   parameter int MAX_STEPS = 255
)
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PRICE_W-1:0]  req_spot_price,
   input  logic [PRICE_W-1:0]  req_strike_price,
   input  logic                req_is_put,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PRICE_W-1:0]  rsp_option_price,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int DEPTH = MAX_STEPS + 1;
   localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (IDX_W > STEP_W) ? IDX_W : STEP_W;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_STEPS);

   // ---------------------------------------------------------------- CSRs
   logic [STEP_W-1:0] cfg_steps_ff;
   logic [31:0]       cfg_up_ff;
   logic [30:0]       cfg_down_ff;
   logic [30:0]       cfg_disc_ff;
   logic [30:0]       cfg_prob_ff;

   logic          csr_wr;
   csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_steps_ff <= RST_STEP_COUNT;
         cfg_up_ff    <= RST_UP_FACTOR;
         cfg_down_ff  <= RST_DOWN;
         cfg_disc_ff  <= RST_DISCOUNT;
         cfg_prob_ff  <= RST_UP_PROB;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_STEP_COUNT:     cfg_steps_ff <= csr_pwdata[STEP_W-1:0];
            CSR_UP_FACTOR:      cfg_up_ff    <= csr_pwdata;
            CSR_DOWN_FACTOR:    cfg_down_ff  <= csr_pwdata[30:0];
            CSR_STEP_DISCOUNT:  cfg_disc_ff  <= csr_pwdata[30:0];
            CSR_UP_PROBABILITY: cfg_prob_ff  <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_STEP_COUNT:     csr_prdata = 32'(cfg_steps_ff);
         CSR_UP_FACTOR:      csr_prdata = cfg_up_ff;
         CSR_DOWN_FACTOR:    csr_prdata = {1'b0, cfg_down_ff};
         CSR_STEP_DISCOUNT:  csr_prdata = {1'b0, cfg_disc_ff};
         CSR_UP_PROBABILITY: csr_prdata = {1'b0, cfg_prob_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // q clamped to 1; user must keep weights constant while a word is in flight
   logic [30:0] q_eff;
   logic [30:0] qc_eff;
   assign q_eff  = (cfg_prob_ff > Q_ONE) ? Q_ONE : cfg_prob_ff;
   assign qc_eff = Q_ONE - q_eff;

   // steps in use, clamped to MAX_STEPS (one less than the store depth)
   logic [CMP_W-1:0] steps_ext;
   logic [IDX_W-1:0] n_clamp;
   assign steps_ext = CMP_W'(cfg_steps_ff);
   assign n_clamp   = (steps_ext > CMP_W'(MAX_STEPS)) ? MAX_IDX : steps_ext[IDX_W-1:0];

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [IDX_W-1:0]   n_ff, n_in;       // lattice steps for this word
   logic [IDX_W-1:0]   i_ff, i_in;       // node index
   logic [IDX_W-1:0]   k_ff, k_in;       // up moves applied to current leaf
   logic [IDX_W-1:0]   s_ff, s_in;       // nodes produced by current fold level
   logic [PRICE_W-1:0] val_ff, val_in;   // running price / mix / root
   logic [PRICE_W-1:0] vlo_ff, vlo_in;   // v[i] of the level being folded
   logic [PRICE_W-1:0] vhi_ff, vhi_in;   // v[i+1]
   logic [PROD_W-1:0]  acc_ff, acc_in;   // q * v[i+1]
   logic [PRICE_W-1:0] strike_ff, strike_in;
   logic               put_ff, put_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0] rsp_price_ff, rsp_price_in;

   // node store
   logic [PRICE_W-1:0] node_mem [DEPTH];
   logic [PRICE_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [IDX_W-1:0]   mem_raddr;
   logic [PRICE_W-1:0] mem_wdata;

   // shared multiplier
   logic [PRICE_W-1:0] mul_a;
   logic [FACT_W-1:0]  mul_b;
   logic [PROD_W-1:0]  prod;

   blop_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   logic [PRICE_W-1:0] prod_rnd;
   logic [PRICE_W-1:0] mix_rnd;
   logic [PRICE_W-1:0] leaf_pay;
   logic [IDX_W:0]     i_inc;
   logic               lvl_end;
   logic               out_free;
   logic               req_take;

   assign prod_rnd = qround(prod);
   assign mix_rnd  = qround(acc_ff + prod);   // both terms < 2^62, no overflow
   assign leaf_pay = payoff(val_ff, strike_ff, put_ff);
   assign i_inc    = {1'b0, i_ff} + 1'b1;
   assign lvl_end  = (i_inc == {1'b0, s_ff});
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign req_take = req_valid & req_ready;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_option_price = rsp_price_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DN_WR;
         ST_DN_WR:  state_in = (i_ff == '0) ? ST_LF_RD : ST_DN_MUL;
         ST_DN_MUL: state_in = ST_DN_WR;
         ST_LF_RD:  state_in = ST_LF_LD;
         ST_LF_LD:  state_in = ST_LF_CHK;
         ST_LF_CHK: state_in = (k_ff == i_ff) ? ST_LF_WR : ST_LF_MUL;
         ST_LF_MUL: state_in = ST_LF_CHK;
         ST_LF_WR: begin
            if (i_ff != n_ff) state_in = ST_LF_LD;
            else if (n_ff == '0) state_in = ST_FIN;
            else state_in = ST_FD_LO;
         end
         ST_FD_LO:  state_in = ST_FD_MUP;
         ST_FD_MUP: state_in = ST_FD_MDN;
         ST_FD_MDN: state_in = ST_FD_MIX;
         ST_FD_MIX: state_in = ST_FD_MDS;
         ST_FD_MDS: state_in = ST_FD_WR;
         ST_FD_WR: begin
            if (!lvl_end) state_in = ST_FD_MUP;
            else if (s_ff == IDX_W'(1)) state_in = ST_FIN;
            else state_in = ST_FD_LO;
         end
         ST_FIN:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      val_in       = val_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      acc_in       = acc_ff;
      strike_in    = strike_ff;
      put_in       = put_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_price_in = rsp_price_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_ff;
      mem_wdata    = leaf_pay;
      mem_raddr    = i_ff;
      mul_a        = val_ff;
      mul_b        = {1'b0, cfg_down_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in      = n_clamp;
               i_in      = n_clamp;       // down chain fills from the top
               val_in    = req_spot_price;
               strike_in = req_strike_price;
               put_in    = req_is_put;
            end
         end
         // node[i] gets spot after (N - i) down moves
         ST_DN_WR: begin
            mem_we    = 1'b1;
            mem_wdata = val_ff;
         end
         ST_DN_MUL: begin
            val_in = prod_rnd;
            i_in   = i_ff - 1'b1;
         end
         ST_LF_RD: begin
            k_in = '0;
         end
         ST_LF_LD: begin
            val_in = rd_data_ff;
         end
         ST_LF_CHK: begin
            mul_b = cfg_up_ff;
         end
         ST_LF_MUL: begin
            val_in = prod_rnd;
            k_in   = k_ff + 1'b1;
         end
         ST_LF_WR: begin
            mem_we = 1'b1;
            if (i_ff != n_ff) begin
               i_in      = i_inc[IDX_W-1:0];
               mem_raddr = i_inc[IDX_W-1:0];
               k_in      = '0;
            end else if (n_ff == '0) begin
               val_in = leaf_pay;         // zero steps: root is the spot payoff
            end else begin
               s_in      = n_ff;
               i_in      = '0;
               mem_raddr = '0;
            end
         end
         ST_FD_LO: begin
            vlo_in    = rd_data_ff;
            mem_raddr = i_inc[IDX_W-1:0];
         end
         ST_FD_MUP: begin
            vhi_in = rd_data_ff;
            mul_a  = rd_data_ff;
            mul_b  = {1'b0, q_eff};
         end
         ST_FD_MDN: begin
            acc_in = prod;
            mul_a  = vlo_ff;
            mul_b  = {1'b0, qc_eff};
         end
         ST_FD_MIX: begin
            val_in = mix_rnd;
         end
         ST_FD_MDS: begin
            mul_b = {1'b0, cfg_disc_ff};
         end
         ST_FD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = prod_rnd;
            vlo_in    = vhi_ff;
            if (!lvl_end) begin
               i_in      = i_inc[IDX_W-1:0];
               mem_raddr = IDX_W'(i_inc + 1'b1);
            end else if (s_ff == IDX_W'(1)) begin
               val_in = prod_rnd;         // root node
            end else begin
               s_in      = s_ff - 1'b1;
               i_in      = '0;
               mem_raddr = '0;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_price_in = val_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      s_ff         <= s_in;
      val_ff       <= val_in;
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      acc_ff       <= acc_in;
      strike_ff    <= strike_in;
      put_ff       <= put_in;
      rsp_price_ff <= rsp_price_in;
   end

   // node store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= node_mem[mem_raddr];
   end

endmodule
